// ===== rtl/core/cmdtok_pkg.sv =====
// Package for the command-line tokenizer: widths, character codes, result
// kinds, status codes, state and result types.
// No dependencies.
package cmdtok_pkg;

  localparam int CHAR_W     = 8;
  localparam int POS_W      = 12;
  localparam int LINE_LIMIT = 4096;
  localparam int NEST_LIMIT = 15;
  localparam int MAX_RES    = 4;
  localparam int RES_CNT_W  = $clog2(MAX_RES + 1);
  localparam int RES_IDX_W  = $clog2(MAX_RES);
  localparam int NEST_W     = $clog2(NEST_LIMIT + 1);

  // positions saturate at the smaller of LINE_LIMIT-1 and the field range
  localparam int POS_MAX_I  = ((LINE_LIMIT - 1) < ((1 << POS_W) - 1)) ?
                              (LINE_LIMIT - 1) : ((1 << POS_W) - 1);
  localparam logic [POS_W-1:0]  POS_MAX  = POS_W'(POS_MAX_I);
  localparam logic [NEST_W-1:0] NEST_MAX = NEST_W'(NEST_LIMIT);

  localparam logic [CHAR_W-1:0] CH_QUOTE   = 8'h22;
  localparam logic [CHAR_W-1:0] CH_BANG    = 8'h21;
  localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_LPAREN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'h20;

  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_QUOTE    = 2'd1;
  localparam logic [1:0] ST_PAREN    = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic              inside_quotes;
    logic              quote_pending;
    logic              inside_comment;
    logic [NEST_W-1:0] nest_depth;
    logic              token_has_chars;
    logic              token_quoted;
    logic              token_qualifier;
    logic [POS_W-1:0]  token_begin;
    logic [POS_W-1:0]  char_index;
    logic [POS_W-1:0]  open_quote_index;
    logic [POS_W-1:0]  open_paren_index;
    logic              any_token_seen;
  } tok_state_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CHAR_W-1:0] char_out;
    logic              qual_flag;
    logic              quoted_flag;
    logic [POS_W-1:0]  token_position;
    logic [1:0]        status;
    logic [POS_W-1:0]  err_pos;
    logic              last;
  } res_t;

  typedef res_t [MAX_RES-1:0] res_vec_t;

  function automatic res_t mk_res(input logic [1:0] kind, input logic [CHAR_W-1:0] ch,
                                  input logic qual, input logic quo,
                                  input logic [POS_W-1:0] pos, input logic [1:0] st,
                                  input logic [POS_W-1:0] epos, input logic last);
    res_t r;
    r.kind           = kind;
    r.char_out       = ch;
    r.qual_flag      = qual;
    r.quoted_flag    = quo;
    r.token_position = pos;
    r.status         = st;
    r.err_pos        = epos;
    r.last           = last;
    return r;
  endfunction

endpackage

// ===== rtl/core/cmdtok_if.sv =====
// Channel interfaces of the command-line tokenizer: character words in,
// result words out. Depends on cmdtok_pkg.
interface cmdtok_in_if import cmdtok_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              line_end;

  modport source (output valid, char_in, line_end, input ready);
  modport sink   (input valid, char_in, line_end, output ready);
endinterface

interface cmdtok_out_if import cmdtok_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [CHAR_W-1:0] char_out;
  logic              qual_flag;
  logic              quoted_flag;
  logic [POS_W-1:0]  token_position;
  logic [1:0]        status;
  logic [POS_W-1:0]  err_pos;
  logic              last;

  modport source (output valid, kind, char_out, qual_flag, quoted_flag, token_position,
                  status, err_pos, last, input ready);
  modport sink   (input valid, kind, char_out, qual_flag, quoted_flag, token_position,
                  status, err_pos, last, output ready);
endinterface

// ===== rtl/core/cmdtok_step.sv =====
// Next-state and result logic for one character: quoting, comments, nesting,
// token splitting and the line status. Depends on cmdtok_pkg.
module cmdtok_step import cmdtok_pkg::*; (
  input  tok_state_t              st_cur,
  input  logic [CHAR_W-1:0]       char_in,
  input  logic                    line_end,
  output tok_state_t              st_nxt,
  output res_vec_t                res,
  output logic [RES_CNT_W-1:0]    res_cnt
);

  always_comb begin : step_proc
    tok_state_t          s;
    res_vec_t            r;
    logic [RES_CNT_W-1:0] n;
    logic [CHAR_W-1:0]   c;
    logic [POS_W-1:0]    idx;
    logic [POS_W:0]      idx_inc;
    logic [POS_W-1:0]    idx_sat;
    logic                done;
    logic [1:0]          st_code;
    logic [POS_W-1:0]    epos;

    s       = st_cur;
    r       = '0;
    n       = '0;
    c       = char_in;
    idx     = st_cur.char_index;
    idx_inc = {1'b0, idx} + {{POS_W{1'b0}}, 1'b1};
    idx_sat = (idx_inc > {1'b0, POS_MAX}) ? POS_MAX : idx_inc[POS_W-1:0];
    done    = 1'b0;
    st_code = ST_OK;
    epos    = '0;

    if (s.inside_comment) begin
      done = 1'b1;
    end else if (s.inside_quotes) begin
      if (s.quote_pending) begin
        s.quote_pending = 1'b0;
        if (c == CH_QUOTE) begin
          // doubled quote: one literal quote
          r[n[RES_IDX_W-1:0]] = mk_res(KIND_CHAR, CH_QUOTE, 1'b0, 1'b0, '0, ST_OK, '0, 1'b0);
          n = n + 1'b1;
          s.token_has_chars = 1'b1;
          done = 1'b1;
        end else begin
          s.inside_quotes = 1'b0;
        end
      end else if (c == CH_QUOTE) begin
        s.quote_pending = 1'b1;
        done = 1'b1;
      end else begin
        r[n[RES_IDX_W-1:0]] = mk_res(KIND_CHAR, c, 1'b0, 1'b0, '0, ST_OK, '0, 1'b0);
        n = n + 1'b1;
        s.token_has_chars = 1'b1;
        done = 1'b1;
      end
    end

    if (!done) begin
      priority if (c == CH_QUOTE) begin
        s.inside_quotes    = 1'b1;
        s.open_quote_index = idx;
        s.token_quoted     = 1'b1;
        if (!s.token_has_chars) s.token_begin = idx;
      end else if (c == CH_BANG) begin
        s.inside_comment = 1'b1;
      end else if (c == CH_LPAREN) begin
        if (s.nest_depth == '0) s.open_paren_index = idx;
        if (s.nest_depth < NEST_MAX) s.nest_depth = s.nest_depth + 1'b1;
        r[n[RES_IDX_W-1:0]] = mk_res(KIND_CHAR, c, 1'b0, 1'b0, '0, ST_OK, '0, 1'b0);
        n = n + 1'b1;
        s.token_has_chars = 1'b1;
      end else if (c == CH_RPAREN) begin
        if (s.nest_depth != '0) s.nest_depth = s.nest_depth - 1'b1;
        r[n[RES_IDX_W-1:0]] = mk_res(KIND_CHAR, c, 1'b0, 1'b0, '0, ST_OK, '0, 1'b0);
        n = n + 1'b1;
        s.token_has_chars = 1'b1;
      end else if (s.nest_depth != '0) begin
        r[n[RES_IDX_W-1:0]] = mk_res(KIND_CHAR, c, 1'b0, 1'b0, '0, ST_OK, '0, 1'b0);
        n = n + 1'b1;
        s.token_has_chars = 1'b1;
      end else if (c == CH_SLASH) begin
        if (s.token_has_chars || s.token_quoted) begin
          r[n[RES_IDX_W-1:0]] = mk_res(KIND_END, '0, s.token_qualifier, s.token_quoted,
                                       s.token_begin, ST_OK, '0, 1'b0);
          n = n + 1'b1;
          s.any_token_seen  = 1'b1;
          s.token_has_chars = 1'b0;
          s.token_quoted    = 1'b0;
          s.token_qualifier = 1'b0;
        end
        s.token_begin = idx;
        r[n[RES_IDX_W-1:0]] = mk_res(KIND_CHAR, CH_SLASH, 1'b0, 1'b0, '0, ST_OK, '0, 1'b0);
        n = n + 1'b1;
        s.token_has_chars = 1'b1;
        s.token_qualifier = 1'b1;
      end else if (c == CH_SPACE || c == CH_TAB) begin
        if (s.token_has_chars || s.token_quoted) begin
          r[n[RES_IDX_W-1:0]] = mk_res(KIND_END, '0, s.token_qualifier, s.token_quoted,
                                       s.token_begin, ST_OK, '0, 1'b0);
          n = n + 1'b1;
          s.any_token_seen  = 1'b1;
          s.token_has_chars = 1'b0;
          s.token_quoted    = 1'b0;
          s.token_qualifier = 1'b0;
        end
        s.token_begin = idx_sat;
      end else begin
        if (!s.token_has_chars) s.token_begin = idx;
        // fold a-z until a quote shows up in the token
        if (!s.token_quoted && c >= CH_LOWER_A && c <= CH_LOWER_Z) c = c - CASE_DIFF;
        r[n[RES_IDX_W-1:0]] = mk_res(KIND_CHAR, c, 1'b0, 1'b0, '0, ST_OK, '0, 1'b0);
        n = n + 1'b1;
        s.token_has_chars = 1'b1;
      end
    end

    if (!line_end) begin
      s.char_index = idx_sat;
    end else begin
      // a quote still pending at the end closes the literal
      if (s.quote_pending) begin
        s.quote_pending = 1'b0;
        s.inside_quotes = 1'b0;
      end
      if (s.token_has_chars || s.token_quoted) begin
        r[n[RES_IDX_W-1:0]] = mk_res(KIND_END, '0, s.token_qualifier, s.token_quoted,
                                     s.token_begin, ST_OK, '0, 1'b0);
        n = n + 1'b1;
        s.any_token_seen = 1'b1;
      end
      priority if (s.inside_quotes) begin
        st_code = ST_QUOTE;
        epos    = s.open_quote_index;
      end else if (s.nest_depth != '0) begin
        st_code = ST_PAREN;
        epos    = s.open_paren_index;
      end else if (!s.any_token_seen) begin
        st_code = ST_EMPTY;
      end else begin
        st_code = ST_OK;
      end
      r[n[RES_IDX_W-1:0]] = mk_res(KIND_STATUS, '0, 1'b0, 1'b0, '0, st_code, epos, 1'b1);
      n = n + 1'b1;
      s = '0;
    end

    st_nxt  = s;
    res     = r;
    res_cnt = n;
  end

endmodule

// ===== rtl/core/cmdtok_outq.sv =====
// Result buffer: holds the up to four results of one character and hands
// them out one word per cycle while the output side is ready. Depends on cmdtok_pkg.
module cmdtok_outq import cmdtok_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  res_vec_t             load_res,
  input  logic [RES_CNT_W-1:0] load_cnt,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output res_t                 out_res
);

  res_vec_t             res_r;
  logic [RES_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RES_IDX_W-1:0] head_r, head_nxt;
  logic                 pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  // free now, or the last word leaves this cycle
  assign can_load  = (cnt_r == '0) || ((cnt_r == RES_CNT_W'(1)) && out_ready);
  assign out_res   = res_r[head_r];

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    if (load) begin
      cnt_nxt  = load_cnt;
      head_nxt = '0;
    end else if (pop) begin
      cnt_nxt  = cnt_r - 1'b1;
      head_nxt = head_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      head_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      head_r <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

endmodule

// ===== rtl/core/command_line_tokenizer.sv =====
// Command-line tokenizer: takes one character word per cycle while ready and
// produces token characters, token-end words and one line status word per line.
// An accepted character is held in the input register; its results (zero to
// four) then load the result buffer, which hands out one word per cycle while
// the output side is ready. Input is taken every cycle as long as each character
// makes at most one result and the output side takes a word every cycle; a
// character that makes more results holds the input until the last word of the
// result buffer leaves through its single output port. State starts fresh after
// each line end, so lines need no separator beyond the line_end flag.
// Depends on cmdtok_pkg, cmdtok_if, cmdtok_step and cmdtok_outq.
module command_line_tokenizer import cmdtok_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  cmdtok_in_if.sink    in_ch,
  cmdtok_out_if.source out_ch
);

  logic                 in_vld_r;
  logic [CHAR_W-1:0]    in_char_r;
  logic                 in_le_r;
  tok_state_t           state_r, state_nxt;
  res_vec_t             step_res;
  logic [RES_CNT_W-1:0] step_cnt;
  logic                 can_load;
  logic                 process;
  logic                 q_valid;
  res_t                 q_res;

  assign process     = in_vld_r && can_load;
  assign in_ch.ready = !in_vld_r || process;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      state_r  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_vld_r <= 1'b1;
      end else if (process) begin
        in_vld_r <= 1'b0;
      end
      if (process) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_char_r <= in_ch.char_in;
      in_le_r   <= in_ch.line_end;
    end
  end

  cmdtok_step u_step (
    .st_cur   (state_r),
    .char_in  (in_char_r),
    .line_end (in_le_r),
    .st_nxt   (state_nxt),
    .res      (step_res),
    .res_cnt  (step_cnt)
  );

  cmdtok_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (process),
    .load_res  (step_res),
    .load_cnt  (step_cnt),
    .can_load  (can_load),
    .out_valid (q_valid),
    .out_ready (out_ch.ready),
    .out_res   (q_res)
  );

  assign out_ch.valid          = q_valid;
  assign out_ch.kind           = q_res.kind;
  assign out_ch.char_out       = q_res.char_out;
  assign out_ch.qual_flag      = q_res.qual_flag;
  assign out_ch.quoted_flag    = q_res.quoted_flag;
  assign out_ch.token_position = q_res.token_position;
  assign out_ch.status         = q_res.status;
  assign out_ch.err_pos        = q_res.err_pos;
  assign out_ch.last           = q_res.last;

endmodule

// ===== rtl/core/cmdtok_chk.sv =====
// Port-level checks for the command-line tokenizer and the bind that attaches
// them to the top level. Depends on cmdtok_pkg and command_line_tokenizer.
module cmdtok_chk import cmdtok_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        kind,
  input logic [CHAR_W-1:0] char_out,
  input logic [1:0]        status,
  input logic [POS_W-1:0]  err_pos,
  input logic              last
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(char_out) &&
      $stable(status) && $stable(err_pos) && $stable(last))
    else $error("result word changed while stalled");

  // last marks exactly the status word
  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last == (kind == KIND_STATUS)))
    else $error("last flag disagrees with status kind");

  // only a character word carries a character
  a_char_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind != KIND_CHAR |-> char_out == '0)
    else $error("character on a non-character word");

  // an error position comes only with an unclosed quote or parenthesis
  a_epos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_OK || status == ST_EMPTY || kind != KIND_STATUS)
      |-> err_pos == '0)
    else $error("error position without an open quote or parenthesis");

endmodule

bind command_line_tokenizer cmdtok_chk u_cmdtok_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .kind      (out_ch.kind),
  .char_out  (out_ch.char_out),
  .status    (out_ch.status),
  .err_pos   (out_ch.err_pos),
  .last      (out_ch.last)
);

// ===== bench/cmdtok_result_checker.sv =====
// Result checker for the command-line tokenizer: follows the character and
// result channels, predicts every line's result words and compares them in order.
// Depends on cmdtok_pkg and cmdtok_if.
module cmdtok_result_checker import cmdtok_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  cmdtok_in_if  in_mon,
  cmdtok_out_if out_mon,
  output int    fail_count,
  output int    awaiting
);

  localparam int REPORT_MAX = 100;

  // lexer state of the line in progress
  logic              in_literal;
  logic              quote_wait;
  logic              in_remark;
  logic [NEST_W-1:0] depth;
  logic              tok_nonempty;
  logic              tok_quoted;
  logic              tok_qual;
  logic [POS_W-1:0]  tok_start;
  logic [POS_W-1:0]  char_pos;
  logic [POS_W-1:0]  quote_at;
  logic [POS_W-1:0]  paren_at;
  logic              seen_token;

  res_t predicted_tokens[$];
  int   words_this_char;

  function automatic logic [POS_W-1:0] clamp_pos(input int unsigned p);
    return (p > POS_MAX_I) ? POS_MAX : POS_W'(p);
  endfunction

  task automatic clear_line();
    in_literal   = 1'b0;
    quote_wait   = 1'b0;
    in_remark    = 1'b0;
    depth        = '0;
    tok_nonempty = 1'b0;
    tok_quoted   = 1'b0;
    tok_qual     = 1'b0;
    tok_start    = '0;
    char_pos     = '0;
    quote_at     = '0;
    paren_at     = '0;
    seen_token   = 1'b0;
  endtask

  task automatic push_word(input res_t r);
    if (words_this_char < MAX_RES) begin
      predicted_tokens = {predicted_tokens, r};
      words_this_char++;
    end
  endtask

  task automatic emit_char(input logic [CHAR_W-1:0] c);
    res_t r;
    r = '0;
    r.kind = KIND_CHAR;
    r.char_out = c;
    push_word(r);
    tok_nonempty = 1'b1;
  endtask

  // a token that only saw quotes still counts
  task automatic close_token(input logic [POS_W-1:0] next_start);
    res_t r;
    if (tok_nonempty || tok_quoted) begin
      r = '0;
      r.kind = KIND_END;
      r.qual_flag = tok_qual;
      r.quoted_flag = tok_quoted;
      r.token_position = tok_start;
      push_word(r);
      seen_token   = 1'b1;
      tok_nonempty = 1'b0;
      tok_quoted   = 1'b0;
      tok_qual     = 1'b0;
    end
    tok_start = next_start;
  endtask

  task automatic lex_char(input logic [CHAR_W-1:0] c_in, input logic le);
    logic [CHAR_W-1:0] c;
    logic [POS_W-1:0]  idx;
    logic              done;
    res_t              r;
    c = c_in;
    idx = char_pos;
    done = in_remark;
    words_this_char = 0;
    if (!done && in_literal) begin
      if (quote_wait) begin
        quote_wait = 1'b0;
        if (c == CH_QUOTE) begin
          emit_char(CH_QUOTE);
          done = 1'b1;
        end else begin
          // literal closed by the previous quote; c is plain text
          in_literal = 1'b0;
        end
      end else if (c == CH_QUOTE) begin
        quote_wait = 1'b1;
        done = 1'b1;
      end else begin
        emit_char(c);
        done = 1'b1;
      end
    end
    if (!done) begin
      if (c == CH_QUOTE) begin
        in_literal = 1'b1;
        quote_at = idx;
        tok_quoted = 1'b1;
        if (!tok_nonempty) tok_start = idx;
      end else if (c == CH_BANG) begin
        in_remark = 1'b1;
      end else if (c == CH_LPAREN) begin
        if (depth == 0) paren_at = idx;
        if (depth < NEST_MAX) depth++;
        emit_char(c);
      end else if (c == CH_RPAREN) begin
        if (depth != 0) depth--;
        emit_char(c);
      end else if (depth != 0) begin
        emit_char(c);
      end else if (c == CH_SLASH) begin
        close_token(idx);
        emit_char(CH_SLASH);
        tok_qual = 1'b1;
      end else if (c == CH_SPACE || c == CH_TAB) begin
        close_token(clamp_pos(idx + 1));
      end else begin
        if (!tok_nonempty) tok_start = idx;
        if (!tok_quoted && c >= CH_LOWER_A && c <= CH_LOWER_Z) c = c - CASE_DIFF;
        emit_char(c);
      end
    end
    if (!le) begin
      char_pos = clamp_pos(char_pos + 1);
    end else begin
      if (quote_wait) begin
        quote_wait = 1'b0;
        in_literal = 1'b0;
      end
      close_token('0);
      r = '0;
      r.kind = KIND_STATUS;
      r.last = 1'b1;
      if (in_literal) begin
        r.status = ST_QUOTE;
        r.err_pos = quote_at;
      end else if (depth != 0) begin
        r.status = ST_PAREN;
        r.err_pos = paren_at;
      end else if (!seen_token) begin
        r.status = ST_EMPTY;
      end else begin
        r.status = ST_OK;
      end
      push_word(r);
      clear_line();
    end
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      clear_line();
      predicted_tokens.delete();
      fail_count = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) lex_char(in_mon.char_in, in_mon.line_end);
      if (out_mon.valid && out_mon.ready) begin
        got.kind           = out_mon.kind;
        got.char_out       = out_mon.char_out;
        got.qual_flag      = out_mon.qual_flag;
        got.quoted_flag    = out_mon.quoted_flag;
        got.token_position = out_mon.token_position;
        got.status         = out_mon.status;
        got.err_pos        = out_mon.err_pos;
        got.last           = out_mon.last;
        if (predicted_tokens.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("%0t: unexpected result word: expected none, actual kind=%0d ",
                     $time, got.kind, "char=%02h status=%0d last=%b",
                     got.char_out, got.status, got.last);
        end else begin
          want = predicted_tokens.pop_front();
          if (got.kind !== want.kind || got.char_out !== want.char_out ||
              got.qual_flag !== want.qual_flag || got.quoted_flag !== want.quoted_flag ||
              got.token_position !== want.token_position || got.status !== want.status ||
              got.err_pos !== want.err_pos || got.last !== want.last) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("%0t: result mismatch: expected kind=%0d char=%02h qual=%b quoted=%b ",
                       $time, want.kind, want.char_out, want.qual_flag, want.quoted_flag,
                       "pos=%0d status=%0d epos=%0d last=%b; ", want.token_position,
                       want.status, want.err_pos, want.last,
                       "actual kind=%0d char=%02h qual=%b quoted=%b ", got.kind,
                       got.char_out, got.qual_flag, got.quoted_flag,
                       "pos=%0d status=%0d epos=%0d last=%b", got.token_position,
                       got.status, got.err_pos, got.last);
          end
        end
      end
    end
    awaiting = predicted_tokens.size();
  end

endmodule

// ===== bench/tb_command_line_tokenizer.sv =====
// Testbench top for the command-line tokenizer: drives directed and random command
// lines in bursts, stalls the result side, and reports the verdict of the checker.
// Depends on cmdtok_pkg, cmdtok_if, command_line_tokenizer and cmdtok_result_checker.
module tb_command_line_tokenizer;
  import cmdtok_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 290;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOKE} rx_mode_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   awaiting;
  logic in_taken;
  int   idle_cycles;
  int   burst_left;
  int   items_sent;
  logic [CHAR_W-1:0] line_q[$];

  cmdtok_in_if  in_ch();
  cmdtok_out_if out_ch();

  command_line_tokenizer dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  cmdtok_result_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .fail_count(fail_count),
    .awaiting  (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    in_taken <= in_ch.valid && in_ch.ready;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("tb_command_line_tokenizer failed");
    $finish;
  end

  // result side: stall pattern drawn anew for each span of random length
  initial begin
    rx_mode_t mode;
    int       span;
    out_ch.ready <= 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(32, 200);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default:   out_ch.ready <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic le);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid    <= 1'b1;
    in_ch.char_in  <= c;
    in_ch.line_end <= le;
    do @(negedge clk); while (!in_taken);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_char(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  task automatic add_byte(input logic [CHAR_W-1:0] b);
    line_q = {line_q, b};
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // plain token character: never a quote, bang, paren, slash or blank
  function automatic logic [CHAR_W-1:0] word_char();
    string             punct;
    logic [CHAR_W-1:0] c;
    punct = "-_.=:$*,;#";
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c = CHAR_W'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
      4, 5, 6:    c = CHAR_W'($urandom_range(8'h41, 8'h5A));
      7:          c = CHAR_W'($urandom_range(8'h30, 8'h39));
      8:          c = punct[$urandom_range(0, punct.len() - 1)];
      default: begin
        do c = CHAR_W'($urandom_range(0, 255));
        while (c == CH_QUOTE || c == CH_BANG || c == CH_LPAREN || c == CH_RPAREN ||
               c == CH_SLASH || c == CH_SPACE || c == CH_TAB);
      end
    endcase
    return c;
  endfunction

  task automatic add_word();
    repeat ($urandom_range(1, 6)) add_byte(word_char());
  endtask

  task automatic add_blanks();
    repeat ($urandom_range(1, 2)) add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endtask

  task automatic add_quoted(input bit closed);
    add_byte(CH_QUOTE);
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 9))
        7: add_byte(CH_SPACE);
        8: add_byte($urandom_range(0, 1) ? CH_BANG : CH_LPAREN);
        9: begin
          add_byte(CH_QUOTE);
          add_byte(CH_QUOTE);
        end
        default: add_byte(word_char());
      endcase
    end
    if (closed) add_byte(CH_QUOTE);
  endtask

  task automatic add_group();
    add_byte(CH_LPAREN);
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 5))
        0: add_blanks();
        1: add_byte(CH_SLASH);
        2: begin
          add_byte(CH_LPAREN);
          add_word();
          add_byte(CH_RPAREN);
        end
        3: add_quoted(1'b1);
        default: add_word();
      endcase
    end
    add_byte(CH_RPAREN);
  endtask

  task automatic add_command(input bit broken);
    if ($urandom_range(0, 4) == 0) add_blanks();
    add_word();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 5))
        0: begin
          add_blanks();
          add_word();
        end
        1: begin
          add_blanks();
          add_quoted(1'b1);
        end
        2: begin
          // quotes glued into a token
          add_blanks();
          add_word();
          add_quoted(1'b1);
          add_word();
        end
        3: begin
          add_byte(CH_SLASH);
          add_word();
          if ($urandom_range(0, 1)) begin
            add_text("=");
            if ($urandom_range(0, 1)) add_quoted(1'b1);
            else add_group();
          end
        end
        4: begin
          add_blanks();
          add_group();
        end
        default: begin
          add_blanks();
          add_byte(CH_SLASH);
          add_word();
        end
      endcase
    end
    if (broken) begin
      case ($urandom_range(0, 3))
        0: begin
          add_blanks();
          add_quoted(1'b0);
        end
        1: begin
          add_blanks();
          add_byte(CH_LPAREN);
          add_word();
        end
        2: add_byte(CH_RPAREN);
        default: add_text(" \"\"");
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 1)) add_blanks();
      add_byte(CH_BANG);
      add_word();
    end
    if ($urandom_range(0, 3) == 0) add_blanks();
  endtask

  initial begin
    int random_end;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.char_in  <= '0;
    in_ch.line_end <= 1'b0;
    burst_left = 0;
    items_sent = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // lowercase, qualifier, doubled quote, text right after a closing quote
    add_text("ab/c\"x\"\"y\"z");
    send_line();
    // tab, unmatched close paren, comment
    add_text("\t)!z");
    send_line();
    // empty quoted token, its closing quote pending at line end
    add_text("\"\"");
    send_line();
    add_text("(a");
    send_line();
    add_byte(CH_QUOTE);
    add_byte(8'hFF);
    send_line();
    add_byte(8'h00);
    add_byte(CH_SPACE);
    send_line();
    add_text(" ");
    send_line();

    random_end = items_sent + RANDOM_ITEMS;
    while (items_sent < random_end) begin
      case ($urandom_range(0, 9))
        6: add_command(1'b1);
        7: repeat ($urandom_range(1, 10)) add_byte(CHAR_W'($urandom_range(0, 255)));
        8: begin
          // nesting near and past the depth limit
          repeat ($urandom_range(13, 18)) add_byte(CH_LPAREN);
          add_word();
          repeat ($urandom_range(0, 18)) add_byte(CH_RPAREN);
        end
        9: begin
          add_blanks();
          if ($urandom_range(0, 1)) begin
            add_byte(CH_BANG);
            add_word();
          end
        end
        default: add_command(1'b0);
      endcase
      send_line();
    end

    in_ch.valid <= 1'b0;
    wait (awaiting == 0);
    repeat (16) @(negedge clk);
    if (fail_count == 0)
      $display("tb_command_line_tokenizer passed");
    else
      $display("tb_command_line_tokenizer failed");
    $finish;
  end

endmodule
